>>> src/ebb_pkg.sv
`default_nettype none
package ebb_pkg;

  localparam int unsigned PriceW  = 24;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CntW    = 17;
  localparam int unsigned PnlW    = 42;
  localparam int unsigned SharpeW = 32;

  localparam logic [CntW-1:0] MaxTicks = 17'd65536;

  localparam logic [1:0] RegAlpha     = 2'd0;
  localparam logic [1:0] RegBandWidth = 2'd1;
  localparam logic [1:0] RegMinWindow = 2'd2;

  localparam logic [CfgW-1:0] AlphaRst     = 16'd3277;
  localparam logic [CfgW-1:0] BandWidthRst = 16'd640;
  localparam logic [CfgW-1:0] MinWindowRst = 16'd50;

endpackage
`default_nettype wire

>>> src/ewma_band_breakout_signal.sv
// Channel | Direction | Handshake                  | Payload
// input   | in        | in_valid_i / in_ready_o    | price_i, last_i
// output  | out       | out_valid_o / out_ready_i  | position_o .. done_res_o
// config  | in        | cfg_we_i                   | cfg_idx_i, cfg_data_i
// A seed tick that is not last is taken without leaving the idle state. Every tick after
// the seed runs seven products on the bit-serial shift-add multiplier (one step per multiplier
// bit) and a 32-step square root. A last tick adds the Sharpe ratio, with up to three more
// products, two more square roots and a 31-step divide.
// Reset clears all series state and loads the register defaults.
// A result waiting on out_ready_i does not block the next input beat; the result after it
// waits in the last state, with the input held off, until the output register is free.
`default_nettype none
module ewma_band_breakout_signal (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [ebb_pkg::CfgW-1:0]     cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ebb_pkg::PriceW-1:0]   price_i,
  input  wire logic                         last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [1:0]                 position_o,
  output logic signed [ebb_pkg::PnlW-1:0]   pnl_o,
  output logic [ebb_pkg::CntW-1:0]          trade_count_o,
  output logic [ebb_pkg::CntW-1:0]          win_count_o,
  output logic [ebb_pkg::PnlW-1:0]          drawdown_o,
  output logic signed [ebb_pkg::SharpeW-1:0] sharpe_o,
  output logic                              status_o,
  output logic                              done_res_o
);
  import ebb_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MUL  = 5'd1;
  localparam logic [4:0] S_SQRT = 5'd2;
  localparam logic [4:0] S_DIV  = 5'd3;
  localparam logic [4:0] S_RSQ  = 5'd4;
  localparam logic [4:0] S_E1   = 5'd5;
  localparam logic [4:0] S_E2   = 5'd6;
  localparam logic [4:0] S_V1   = 5'd7;
  localparam logic [4:0] S_V2   = 5'd8;
  localparam logic [4:0] S_V3   = 5'd9;
  localparam logic [4:0] S_VOL  = 5'd10;
  localparam logic [4:0] S_BAND = 5'd11;
  localparam logic [4:0] S_SH0  = 5'd12;
  localparam logic [4:0] S_SH1  = 5'd13;
  localparam logic [4:0] S_SH2  = 5'd14;
  localparam logic [4:0] S_SH3  = 5'd15;
  localparam logic [4:0] S_SH4  = 5'd16;
  localparam logic [4:0] S_SH5  = 5'd17;
  localparam logic [4:0] S_SH6  = 5'd18;
  localparam logic [4:0] S_PUT  = 5'd19;

  logic [4:0] state_q, ret_state_q;
  logic [6:0] cnt_q;

  logic [CfgW-1:0] alpha_q, band_width_q, min_window_q;

  logic                     seeded_q, last_q;
  logic [PriceW-1:0]        px_q, prev_q;
  logic [PriceW+15:0]       ewma_q;
  logic [63:0]              var_q;
  logic signed [1:0]        held_q;
  logic signed [PnlW-1:0]   pnl_q, peak_q, min_q, rsum_q;
  logic [CntW-1:0]          trades_q, wins_q, tick_q;
  logic [63:0]              rsq_q;
  logic signed [PriceW:0]   ret_q;
  logic [127:0]             tmp_q;
  logic [63:0]              den_q;
  logic [SharpeW-1:0]       shp_q;

  logic [127:0] m_acc_q, m_a_q;
  logic [63:0]  m_b_q;
  logic [127:0] sq_x_q;
  logic [65:0]  sq_rem_q;
  logic [63:0]  sq_root_q;

  logic [127:0] mul_acc_nx;
  logic [67:0]  sq_r2, sq_trial;
  logic         sq_ge;
  logic         div_ge;
  logic [PriceW+15:0] p16, enew, emag;
  logic [PriceW+16:0] esum;
  logic [64:0]  vsum;
  logic [63:0]  vsat, rsq_sat;
  logic [64:0]  rsq_sum;
  logic [49:0]  band_hi, band_lo;
  logic signed [1:0] new_pos;
  logic signed [PriceW+1:0] pnl_term;
  logic signed [PnlW:0] pnl_sum, rsum_sum;
  logic signed [PnlW-1:0] pnl_sat, rsum_sat;
  logic [CntW-1:0] n_ret, tick_inc, trades_inc, wins_inc;
  logic [PnlW-1:0] s_mag;
  logic [PriceW-1:0] ret_mag;
  logic [PnlW:0] dd_full;
  logic [CntW:0] win_lim;
  logic [31:0] vol_fl;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    mul_acc_nx = m_b_q[0] ? m_acc_q + m_a_q : m_acc_q;
    sq_r2      = {sq_rem_q, sq_x_q[127:126]};
    sq_trial   = {2'b00, sq_root_q, 2'b01};
    sq_ge      = (sq_r2 >= sq_trial);
    div_ge     = (m_acc_q >= m_a_q);

    p16     = {px_q, 16'h0000};
    esum    = {1'b0, tmp_q[PriceW+15:0]} + {1'b0, m_acc_q[PriceW+31:16]};
    enew    = esum[PriceW+15:0];
    emag    = (p16 >= enew) ? p16 - enew : enew - p16;
    vsum    = {1'b0, var_q} + {1'b0, m_acc_q[79:16]};
    vsat    = vsum[64] ? {64{1'b1}} : vsum[63:0];
    rsq_sum = {1'b0, rsq_q} + {1'b0, m_acc_q[63:0]};
    rsq_sat = rsq_sum[64] ? {64{1'b1}} : rsq_sum[63:0];

    band_hi = {10'd0, ewma_q} + {2'd0, m_acc_q[47:0]};
    band_lo = {10'd0, p16} + {2'd0, m_acc_q[47:0]};
    if ({10'd0, p16} > band_hi) begin
      new_pos = 2'sd1;
    end else if (band_lo < {10'd0, ewma_q}) begin
      new_pos = -2'sd1;
    end else begin
      new_pos = held_q;
    end

    case (held_q)
      2'sd1:   pnl_term = {ret_q[PriceW], ret_q};
      -2'sd1:  pnl_term = -{ret_q[PriceW], ret_q};
      default: pnl_term = '0;
    endcase
    pnl_sum = {pnl_q[PnlW-1], pnl_q} + {{(PnlW-PriceW-1){pnl_term[PriceW+1]}}, pnl_term};
    if (pnl_sum[PnlW] != pnl_sum[PnlW-1]) begin
      pnl_sat = pnl_sum[PnlW] ? {1'b1, {(PnlW-1){1'b0}}} : {1'b0, {(PnlW-1){1'b1}}};
    end else begin
      pnl_sat = pnl_sum[PnlW-1:0];
    end

    ret_mag = ret_q[PriceW] ? PriceW'(-ret_q) : ret_q[PriceW-1:0];

    rsum_sum = {rsum_q[PnlW-1], rsum_q}
             + {{(PnlW-PriceW){ret_q[PriceW]}}, ret_q};
    if (rsum_sum[PnlW] != rsum_sum[PnlW-1]) begin
      rsum_sat = rsum_sum[PnlW] ? {1'b1, {(PnlW-1){1'b0}}} : {1'b0, {(PnlW-1){1'b1}}};
    end else begin
      rsum_sat = rsum_sum[PnlW-1:0];
    end

    s_mag      = rsum_q[PnlW-1] ? PnlW'(-rsum_q) : rsum_q;
    n_ret      = tick_q - 1'b1;
    tick_inc   = (tick_q < MaxTicks) ? tick_q + 1'b1 : tick_q;
    trades_inc = (trades_q < MaxTicks) ? trades_q + 1'b1 : trades_q;
    wins_inc   = (wins_q < MaxTicks) ? wins_q + 1'b1 : wins_q;
    dd_full    = {peak_q[PnlW-1], peak_q} - {min_q[PnlW-1], min_q};
    win_lim    = {2'b00, min_window_q} + 18'd2;
    vol_fl     = (sq_root_q[31:0] == 32'd0) ? 32'd1 : sq_root_q[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q      <= AlphaRst;
      band_width_q <= BandWidthRst;
      min_window_q <= MinWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegAlpha:     alpha_q      <= cfg_data_i;
        RegBandWidth: band_width_q <= cfg_data_i;
        RegMinWindow: min_window_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_state_q <= S_IDLE;
      cnt_q       <= '0;
      seeded_q    <= 1'b0;
      last_q      <= 1'b0;
      px_q        <= '0;
      prev_q      <= '0;
      ewma_q      <= '0;
      var_q       <= '0;
      held_q      <= '0;
      pnl_q       <= '0;
      peak_q      <= '0;
      min_q       <= '0;
      rsum_q      <= '0;
      rsq_q       <= '0;
      trades_q    <= '0;
      wins_q      <= '0;
      tick_q      <= '0;
      ret_q       <= '0;
      tmp_q       <= '0;
      den_q       <= '0;
      shp_q       <= '0;
      m_acc_q     <= '0;
      m_a_q       <= '0;
      m_b_q       <= '0;
      sq_x_q      <= '0;
      sq_rem_q    <= '0;
      sq_root_q   <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && state_q != S_PUT) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            px_q   <= price_i;
            last_q <= last_i;
            tick_q <= tick_inc;
            prev_q <= price_i;
            if (!seeded_q) begin
              seeded_q <= 1'b1;
              ewma_q   <= {price_i, 16'h0000};
              if (last_i) begin
                state_q <= S_SH0;
              end
            end else begin
              ret_q       <= {1'b0, price_i} - {1'b0, prev_q};
              state_q     <= S_RSQ;
            end
          end
        end
        S_RSQ: begin
          rsum_q      <= rsum_sat;
          m_acc_q     <= '0;
          m_a_q       <= {104'd0, ret_mag};
          m_b_q       <= {40'd0, ret_mag};
          ret_state_q <= S_E1;
          state_q     <= S_MUL;
        end
        S_MUL: begin
          if (m_b_q == 64'd0) begin
            state_q <= ret_state_q;
          end else begin
            m_acc_q <= mul_acc_nx;
            m_a_q   <= {m_a_q[126:0], 1'b0};
            m_b_q   <= {1'b0, m_b_q[63:1]};
          end
        end
        S_SQRT: begin
          if (cnt_q == 7'd0) begin
            state_q <= ret_state_q;
          end else begin
            cnt_q     <= cnt_q - 1'b1;
            sq_x_q    <= {sq_x_q[125:0], 2'b00};
            sq_rem_q  <= sq_ge ? 66'(sq_r2 - sq_trial) : sq_r2[65:0];
            sq_root_q <= {sq_root_q[62:0], sq_ge};
          end
        end
        S_DIV: begin
          if (cnt_q == 7'd0) begin
            state_q <= ret_state_q;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            m_acc_q <= div_ge ? m_acc_q - m_a_q : m_acc_q;
            m_b_q   <= {m_b_q[62:0], div_ge};
            m_a_q   <= {1'b0, m_a_q[127:1]};
          end
        end
        S_E1: begin
          rsq_q       <= rsq_sat;
          m_acc_q     <= '0;
          m_a_q       <= {104'd0, px_q};
          m_b_q       <= {48'd0, alpha_q};
          ret_state_q <= S_E2;
          state_q     <= S_MUL;
        end
        S_E2: begin
          tmp_q       <= m_acc_q;
          m_acc_q     <= '0;
          m_a_q       <= {88'd0, ewma_q};
          m_b_q       <= 64'(17'h10000 - {1'b0, alpha_q});
          ret_state_q <= S_V1;
          state_q     <= S_MUL;
        end
        S_V1: begin
          ewma_q      <= enew;
          m_acc_q     <= '0;
          m_a_q       <= {96'd0, emag[PriceW+15:8]};
          m_b_q       <= {32'd0, emag[PriceW+15:8]};
          ret_state_q <= S_V2;
          state_q     <= S_MUL;
        end
        S_V2: begin
          m_acc_q     <= '0;
          m_a_q       <= {64'd0, m_acc_q[63:0]};
          m_b_q       <= {48'd0, alpha_q};
          ret_state_q <= S_V3;
          state_q     <= S_MUL;
        end
        S_V3: begin
          m_acc_q     <= '0;
          m_a_q       <= {64'd0, vsat};
          m_b_q       <= 64'(17'h10000 - {1'b0, alpha_q});
          ret_state_q <= S_VOL;
          state_q     <= S_MUL;
        end
        S_VOL: begin
          var_q       <= m_acc_q[79:16];
          sq_x_q      <= {m_acc_q[79:16], 64'd0};
          sq_rem_q    <= '0;
          sq_root_q   <= '0;
          cnt_q       <= 7'd32;
          ret_state_q <= S_BAND;
          state_q     <= S_SQRT;
        end
        S_BAND: begin
          m_acc_q     <= '0;
          m_a_q       <= {96'd0, vol_fl};
          m_b_q       <= {48'd0, band_width_q};
          ret_state_q <= S_SH0;
          state_q     <= S_MUL;
        end
        S_SH0: begin
          if (seeded_q && tick_q != 17'd1) begin
            if (new_pos != held_q) begin
              trades_q <= trades_inc;
              if ((held_q == 2'sd1 && !ret_q[PriceW] && ret_q != '0) ||
                  (held_q == -2'sd1 && ret_q[PriceW])) begin
                wins_q <= wins_inc;
              end
            end
            pnl_q  <= pnl_sat;
            if (pnl_sat > peak_q) begin
              peak_q <= pnl_sat;
            end
            if (pnl_sat < min_q) begin
              min_q <= pnl_sat;
            end
            held_q <= new_pos;
          end
          shp_q   <= '0;
          if (!last_q || n_ret < 17'd2) begin
            state_q <= S_PUT;
          end else begin
            m_acc_q     <= '0;
            m_a_q       <= {64'd0, rsq_q};
            m_b_q       <= {47'd0, n_ret};
            ret_state_q <= S_SH1;
            state_q     <= S_MUL;
          end
        end
        S_SH1: begin
          tmp_q       <= m_acc_q;
          m_acc_q     <= '0;
          m_a_q       <= {86'd0, s_mag};
          m_b_q       <= {22'd0, s_mag};
          ret_state_q <= S_SH2;
          state_q     <= S_MUL;
        end
        S_SH2: begin
          if (tmp_q <= m_acc_q) begin
            state_q <= S_PUT;
          end else begin
            sq_x_q      <= tmp_q - m_acc_q;
            sq_rem_q    <= '0;
            sq_root_q   <= '0;
            cnt_q       <= 7'd64;
            ret_state_q <= S_SH3;
            state_q     <= S_SQRT;
          end
        end
        S_SH3: begin
          den_q <= sq_root_q;
          if (sq_root_q == 64'd0) begin
            state_q <= S_PUT;
          end else begin
            sq_x_q      <= {15'd0, 17'(n_ret - 1'b1), 32'd0, 64'd0};
            sq_rem_q    <= '0;
            sq_root_q   <= '0;
            cnt_q       <= 7'd32;
            ret_state_q <= S_SH4;
            state_q     <= S_SQRT;
          end
        end
        S_SH4: begin
          m_acc_q     <= '0;
          m_a_q       <= {86'd0, s_mag};
          m_b_q       <= sq_root_q;
          ret_state_q <= S_SH5;
          state_q     <= S_MUL;
        end
        S_SH5: begin
          m_a_q       <= {34'd0, den_q, 30'd0};
          m_b_q       <= '0;
          cnt_q       <= 7'd31;
          ret_state_q <= S_SH6;
          state_q     <= S_DIV;
        end
        S_SH6: begin
          shp_q   <= rsum_q[PnlW-1] ? -{1'b0, m_b_q[30:0]} : {1'b0, m_b_q[30:0]};
          state_q <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            if (last_q) begin
              seeded_q <= 1'b0;
              prev_q   <= '0;
              ewma_q   <= '0;
              var_q    <= '0;
              held_q   <= '0;
              pnl_q    <= '0;
              peak_q   <= '0;
              min_q    <= '0;
              rsum_q   <= '0;
              rsq_q    <= '0;
              trades_q <= '0;
              wins_q   <= '0;
              tick_q   <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PUT && (!out_valid_o || out_ready_i)) begin
      position_o    <= held_q;
      pnl_o         <= pnl_q;
      trade_count_o <= trades_q;
      win_count_o   <= wins_q;
      drawdown_o    <= dd_full[PnlW-1:0];
      sharpe_o      <= shp_q;
      status_o      <= last_q && ({1'b0, tick_q} < win_lim);
      done_res_o    <= last_q;
    end
  end

endmodule
`default_nettype wire

>>> src/ebb_checker.sv
`default_nettype none
module ebb_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic signed [1:0]             position_o,
  input wire logic [ebb_pkg::CntW-1:0]      trade_count_o,
  input wire logic [ebb_pkg::CntW-1:0]      win_count_o,
  input wire logic signed [ebb_pkg::SharpeW-1:0] sharpe_o,
  input wire logic                          status_o,
  input wire logic                          done_res_o
);
  import ebb_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_wins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> win_count_o <= trade_count_o)
    else $error("more wins than trades");

  a_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> sharpe_o == '0 && !status_o)
    else $error("sharpe or status set on a beat that is not last");

  a_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o != -2'sd2)
    else $error("illegal position code");

endmodule

bind ewma_band_breakout_signal ebb_checker u_ebb_checker (.*);
`default_nettype wire
